// ----- rtl/cia_pkg.sv -----
// Shared types, constants and codes for the checked 64-bit integer ALU.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cia_pkg;

  // Width of the arithmetic and of the port fields.
  localparam int DW = 64;
  localparam int IO_W = 64;
  localparam int CMD_W = 3;
  localparam int ST_W = 2;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NEG = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF = 2'd1;
  localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

  // Queue between front and back.
  localparam int QD = 4;
  localparam int QAW = 2;

  // Divider step counter.
  localparam int CNT_W = $clog2(DW);

  // How the back end has to finish an item.
  typedef enum logic [1:0] {
    K_CONST,
    K_MUL,
    K_DIV
  } kind_t;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } dv_state_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    kind_t           kind;
    logic            is_rem;
    logic            neg;
    logic [DW-1:0]   mag_a;
    logic [DW-1:0]   mag_b;
    logic [DW-1:0]   res;
    logic [ST_W-1:0] st;
  } q_entry_t;

  // Request from the back pipeline to the divider.
  typedef struct packed {
    logic          start;
    logic          is_rem;
    logic          neg;
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
  } dv_req_t;

  // Divider status toward the back pipeline.
  typedef struct packed {
    logic          idle;
    logic          done;
    logic [DW-1:0] res;
  } dv_stat_t;

endpackage

`default_nettype wire

// ----- rtl/cia_front.sv -----
// Front end: accepts items, classifies them and finishes the cheap operations.
// Holds the queue toward the back end. Depends on cia_pkg.
`default_nettype none

module cia_front
  import cia_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [IO_W-1:0]   in_operand_a,
  input  wire logic [IO_W-1:0]   in_operand_b,
  output q_entry_t               head,
  output logic                   head_valid,
  input  wire logic              pop
);

  logic [DW-1:0] a, b, sum, dif, neg_a, neg_b;
  logic          sa, sb, ovf_add, ovf_sub, min_a, zero_b, m1_b;
  q_entry_t      ent;
  logic          push;

  q_entry_t      fifo_r [QD];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  // Only the low DW bits of each operand count.
  assign a = in_operand_a[DW-1:0];
  assign b = in_operand_b[DW-1:0];
  assign sa = a[DW-1];
  assign sb = b[DW-1];

  // Adders for add, subtract, negate and the operand magnitudes.
  assign sum = a + b;
  assign dif = a - b;
  assign neg_a = '0 - a;
  assign neg_b = '0 - b;
  assign ovf_add = (sa == sb) && (sum[DW-1] != sa);
  assign ovf_sub = (sa != sb) && (dif[DW-1] != sa);
  assign min_a = sa && (a[DW-2:0] == '0);
  assign zero_b = (b == '0);
  assign m1_b = &b;

  // Classify the item.
  always_comb begin
    ent.kind = K_CONST;
    ent.is_rem = 1'b0;
    ent.neg = 1'b0;
    ent.mag_a = sa ? neg_a : a;
    ent.mag_b = sb ? neg_b : b;
    ent.res = '0;
    ent.st = ST_OK;
    case (in_cmd)
      CMD_ADD: begin
        if (ovf_add) ent.st = ST_OVF;
        else ent.res = sum;
      end
      CMD_SUB: begin
        if (ovf_sub) ent.st = ST_OVF;
        else ent.res = dif;
      end
      CMD_MUL: begin
        ent.kind = K_MUL;
        ent.neg = (sa != sb) && (a != '0) && !zero_b;
      end
      CMD_DIV: begin
        if (zero_b) ent.st = ST_DIVZ;
        else if (min_a && m1_b) ent.st = ST_OVF;
        else begin
          ent.kind = K_DIV;
          ent.neg = sa ^ sb;
        end
      end
      CMD_REM: begin
        if (zero_b) ent.st = ST_DIVZ;
        else if (!(min_a && m1_b)) begin
          ent.kind = K_DIV;
          ent.is_rem = 1'b1;
          ent.neg = sa;
        end
      end
      CMD_NEG: begin
        if (min_a) ent.st = ST_OVF;
        else ent.res = neg_a;
      end
      default: begin
        ent.st = ST_OK;
      end
    endcase
  end

  // Queue control.
  assign in_stall = (cnt_r == (QAW+1)'(QD));
  assign push = in_valid && !in_stall;
  assign head_valid = (cnt_r != '0);
  assign head = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= ent;
  end

endmodule

`default_nettype wire

// ----- rtl/cia_div.sv -----
// Restoring divider, one quotient bit per cycle, with sign fix-up.
// Serves divide and remainder for the back end. Depends on cia_pkg.
`default_nettype none

module cia_div
  import cia_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dv_req_t req,
  input  wire logic    take,
  output dv_stat_t     stat
);

  dv_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]  q_r, rem_r, d_r;
  logic           is_rem_r, neg_r;
  logic [DW:0]    rem_sh, diff;
  logic [DW-1:0]  mag;
  logic           last;

  assign last = (cnt_r == CNT_W'(DW-1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (req.start) state_nxt = DV_RUN;
      DV_RUN:  if (last) state_nxt = DV_DONE;
      DV_DONE: if (take) state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    mag = is_rem_r ? rem_r : q_r;
    stat.idle = 1'b0;
    stat.done = 1'b0;
    stat.res = neg_r ? ('0 - mag) : mag;
    case (state_r)
      DV_IDLE: stat.idle = 1'b1;
      DV_DONE: stat.done = 1'b1;
      default: stat.idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DV_IDLE;
    else state_r <= state_nxt;
  end

  // One trial subtraction per cycle.
  assign rem_sh = {rem_r, q_r[DW-1]};
  assign diff = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && req.start) begin
      q_r <= req.mag_a;
      d_r <= req.mag_b;
      rem_r <= '0;
      cnt_r <= '0;
      is_rem_r <= req.is_rem;
      neg_r <= req.neg;
    end else if (state_r == DV_RUN) begin
      cnt_r <= cnt_r + 1'b1;
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        q_r <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        q_r <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cia_back.sv -----
// Back end: multiply pipeline, divider issue and the output register.
// Drains the front queue in order. Depends on cia_pkg and cia_div.
`default_nettype none

module cia_back
  import cia_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire q_entry_t        head,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [IO_W-1:0]      out_result,
  output logic [ST_W-1:0]      out_status
);

  localparam int LW = DW / 2;
  localparam int UW = DW - LW;

  logic advance, issue_pipe, start_div, div_take;
  dv_req_t  dreq;
  dv_stat_t dstat;

  // Stage 1 registers.
  logic              e1_v_r;
  logic              e1_mul_r, e1_neg_r;
  logic [DW-1:0]     e1_res_r;
  logic [ST_W-1:0]   e1_st_r;
  logic [2*LW-1:0]   e1_ll_r;
  logic [DW-1:0]     e1_lh_r, e1_hl_r;
  logic [2*UW-1:0]   e1_hh_r;

  // Stage 2 registers.
  logic              e2_v_r;
  logic              e2_mul_r, e2_neg_r;
  logic [DW-1:0]     e2_res_r;
  logic [ST_W-1:0]   e2_st_r;
  logic [2*DW-1:0]   e2_p_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     out_res_r, out_res_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;

  logic [2*DW-1:0]   prod;
  logic [DW-1:0]     lo, e3_res;
  logic [ST_W-1:0]   e3_st;
  logic              mul_ovf;
  logic signed [DW-1:0] res_s;

  // Issue: the pipeline moves when the output slot frees up.
  assign advance = !out_valid_r || !out_stall;
  assign issue_pipe = head_valid && (head.kind != K_DIV) && dstat.idle && advance;
  assign start_div = head_valid && (head.kind == K_DIV) && dstat.idle && !e1_v_r && !e2_v_r;
  assign pop = issue_pipe || start_div;
  assign div_take = advance && dstat.done;

  assign dreq.start = start_div;
  assign dreq.is_rem = head.is_rem;
  assign dreq.neg = head.neg;
  assign dreq.mag_a = head.mag_a;
  assign dreq.mag_b = head.mag_b;

  cia_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .take (div_take),
    .stat (dstat)
  );

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      e1_v_r <= issue_pipe;
      e2_v_r <= e1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: four partial products of the magnitudes.
  always_ff @(posedge clk) begin
    if (advance) begin
      e1_mul_r <= (head.kind == K_MUL);
      e1_neg_r <= head.neg;
      e1_res_r <= head.res;
      e1_st_r <= head.st;
      e1_ll_r <= head.mag_a[LW-1:0] * head.mag_b[LW-1:0];
      e1_lh_r <= head.mag_a[LW-1:0] * head.mag_b[DW-1:LW];
      e1_hl_r <= head.mag_a[DW-1:LW] * head.mag_b[LW-1:0];
      e1_hh_r <= head.mag_a[DW-1:LW] * head.mag_b[DW-1:LW];
    end
  end

  // Stage 2: sum of the partial products.
  assign prod = (2*DW)'(e1_ll_r) + ((2*DW)'(e1_lh_r) << LW) + ((2*DW)'(e1_hl_r) << LW)
              + ((2*DW)'(e1_hh_r) << (2*LW));

  always_ff @(posedge clk) begin
    if (advance) begin
      e2_mul_r <= e1_mul_r;
      e2_neg_r <= e1_neg_r;
      e2_res_r <= e1_res_r;
      e2_st_r <= e1_st_r;
      e2_p_r <= prod;
    end
  end

  // Stage 3: range check and sign of the product.
  assign lo = e2_p_r[DW-1:0];
  assign mul_ovf = (e2_p_r[2*DW-1:DW] != '0)
                 || (lo[DW-1] && (!e2_neg_r || (lo[DW-2:0] != '0)));

  always_comb begin
    e3_res = e2_res_r;
    e3_st = e2_st_r;
    if (e2_mul_r) begin
      if (mul_ovf) begin
        e3_res = '0;
        e3_st = ST_OVF;
      end else begin
        e3_res = e2_neg_r ? ('0 - lo) : lo;
        e3_st = ST_OK;
      end
    end
  end

  // Output register takes the pipeline or, when it is empty, the divider.
  always_comb begin
    out_valid_nxt = e2_v_r || dstat.done;
    out_res_nxt = e3_res;
    out_st_nxt = e3_st;
    if (!e2_v_r) begin
      out_res_nxt = dstat.res;
      out_st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= out_res_nxt;
      out_st_r <= out_st_nxt;
    end
  end

  assign res_s = signed'(out_res_r);
  assign out_valid = out_valid_r;
  assign out_result = IO_W'(res_s);
  assign out_status = out_st_r;

endmodule

`default_nettype wire

// ----- rtl/checked_i64_alu.sv -----
// Top level of the checked 64-bit integer ALU.
// Connects cia_front and cia_back. Depends on cia_pkg.
//
//   channel | ports                                   | direction
//   input   | in_valid in_stall in_cmd in_operand_a/b | into the block
//   result  | out_valid out_stall out_result out_status | out of the block
//
// Add, subtract, negate, multiply, unused codes and all faults pass from
// the queue through the pipeline to the output register, one per cycle
// while the output is not stalled and the divider is idle. Divide and
// remainder go through a one-bit-per-cycle divider once the pipeline is
// empty, one at a time, and no other item leaves the queue meanwhile.
// A 4-entry queue lets inputs be taken while the output is stalled.
// Reset is synchronous and clears the queue, pipeline and divider.
`default_nettype none

module checked_i64_alu
  import cia_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CMD_W-1:0] in_cmd,
  input  wire logic [IO_W-1:0]  in_operand_a,
  input  wire logic [IO_W-1:0]  in_operand_b,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [IO_W-1:0]       out_result,
  output logic [ST_W-1:0]       out_status
);

  q_entry_t head;
  logic     head_valid, pop;

  cia_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  cia_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result),
    .out_status(out_status)
  );

endmodule

`default_nettype wire

// ----- rtl/cia_chk.sv -----
// Port-level checker for the checked 64-bit integer ALU, bound to the top level.
// Depends on cia_pkg and checked_i64_alu.
`default_nettype none

module cia_chk
  import cia_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [IO_W-1:0]  out_result,
  input wire logic [ST_W-1:0]  out_status
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result) && $stable(out_status))
    else $error("stalled result changed");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OVF || out_status == ST_DIVZ))
    else $error("undefined status code");

  // A fault always comes with result zero.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result == '0)
    else $error("faulting result not zero");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind checked_i64_alu cia_chk u_cia_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_result(out_result),
  .out_status(out_status)
);

`default_nettype wire

// ----- tb/sv/checked_i64_alu_test.sv -----
// Self-checking testbench for the checked 64-bit integer ALU.
// Drives directed and random operations and compares every transfer with a
// local predictor. Depends on cia_pkg and checked_i64_alu.
`default_nettype none

module checked_i64_alu_test;
  import cia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed; they must behave as no operation.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [IO_W-1:0] I64_MIN = {1'b1, {(IO_W-1){1'b0}}};
  localparam logic [IO_W-1:0] I64_MAX = {1'b0, {(IO_W-1){1'b1}}};
  localparam logic [IO_W-1:0] MINUS_ONE = {IO_W{1'b1}};
  localparam logic [IO_W-1:0] ONE = 64'd1;
  localparam logic [IO_W-1:0] ZERO = 64'd0;

  localparam int RANDOM_OPS = 1100;
  localparam int IDLE_PCT = 36;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [IO_W-1:0] result;
    logic [ST_W-1:0] status;
  } alu_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IO_W-1:0]  a;
    logic [IO_W-1:0]  b;
    bit               known;
    logic [IO_W-1:0]  result;
    logic [ST_W-1:0]  status;
  } directed_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CMD_W-1:0] in_cmd;
  logic [IO_W-1:0]  in_operand_a;
  logic [IO_W-1:0]  in_operand_b;
  logic             out_valid;
  logic             out_stall;
  logic [IO_W-1:0]  out_result;
  logic [ST_W-1:0]  out_status;

  alu_result_t pending_results[$];
  int          mismatches = 0;
  bit          no_idle = 0;
  int          quiet_cycles = 0;

  checked_i64_alu DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result),
    .out_status  (out_status)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // True result of a fault-checked operation.
  function automatic alu_result_t checked_op(logic [CMD_W-1:0] cmd, logic [IO_W-1:0] a,
                                             logic [IO_W-1:0] b);
    logic signed [127:0] wide;
    logic [IO_W-1:0]     mag_a;
    logic [IO_W-1:0]     mag_b;
    logic [IO_W-1:0]     part;
    alu_result_t         r;
    r = '{result: ZERO, status: ST_OK};
    mag_a = a[IO_W-1] ? -a : a;
    mag_b = b[IO_W-1] ? -b : b;
    wide = '0;
    case (cmd)
      CMD_ADD: wide = $signed(a) + $signed(b);
      CMD_SUB: wide = $signed(a) - $signed(b);
      CMD_MUL: wide = $signed(a) * $signed(b);
      CMD_NEG: wide = -$signed({{64{a[IO_W-1]}}, a});
      default: ;
    endcase
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_NEG: begin
        // A result fits when bits 127..63 are all copies of the sign.
        if (wide[127:63] != {65{wide[63]}}) r.status = ST_OVF;
        else r.result = wide[63:0];
      end
      CMD_DIV: begin
        if (b == ZERO) r.status = ST_DIVZ;
        else if (a == I64_MIN && b == MINUS_ONE) r.status = ST_OVF;
        else begin
          part = mag_a / mag_b;
          r.result = (a[IO_W-1] != b[IO_W-1]) ? -part : part;
        end
      end
      CMD_REM: begin
        if (b == ZERO) r.status = ST_DIVZ;
        else begin
          // Most negative remainder minus one lands here and gives zero.
          part = mag_a % mag_b;
          r.result = a[IO_W-1] ? -part : part;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random operand: half extremes and small values, the rest shortened, 32-bit or full-range values.
  function automatic logic [IO_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return I64_MIN;
      1: return I64_MAX;
      2: return MINUS_ONE;
      3: return ZERO;
      4: return 64'($signed($urandom_range(0, 40)) - 20);
      5: return {$urandom, $urandom} >> $urandom_range(0, 63);
      6: return {{32{1'b0}}, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One input transfer; the expected result is queued on acceptance.
  task automatic send_op(logic [CMD_W-1:0] cmd, logic [IO_W-1:0] a, logic [IO_W-1:0] b);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(checked_op(cmd, a, b));
  endtask

  task automatic maybe_idle();
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Receiver stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: result %h status %0d", out_result, out_status);
        mismatches++;
      end else begin
        alu_result_t want;
        want = pending_results.pop_front();
        if (out_result !== want.result) begin
          $error("result: expected %h, actual %h", want.result, out_result);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  directed_row_t directed[] = '{
    '{CMD_ADD, I64_MAX, ONE, 1, ZERO, ST_OVF},
    '{CMD_ADD, I64_MIN, MINUS_ONE, 1, ZERO, ST_OVF},
    '{CMD_ADD, I64_MAX, I64_MIN, 1, MINUS_ONE, ST_OK},
    '{CMD_SUB, I64_MIN, ONE, 1, ZERO, ST_OVF},
    '{CMD_SUB, I64_MAX, MINUS_ONE, 1, ZERO, ST_OVF},
    '{CMD_SUB, ZERO, I64_MIN, 1, ZERO, ST_OVF},
    '{CMD_SUB, ZERO, I64_MAX, 1, I64_MIN + 64'd1, ST_OK},
    '{CMD_MUL, I64_MIN, MINUS_ONE, 1, ZERO, ST_OVF},
    '{CMD_MUL, I64_MAX, I64_MAX, 1, ZERO, ST_OVF},
    '{CMD_MUL, I64_MIN, ONE, 1, I64_MIN, ST_OK},
    '{CMD_MUL, ZERO, I64_MIN, 1, ZERO, ST_OK},
    '{CMD_MUL, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_8000_0000, 0, ZERO, ST_OK},
    '{CMD_DIV, I64_MIN, MINUS_ONE, 1, ZERO, ST_OVF},
    '{CMD_REM, I64_MIN, MINUS_ONE, 1, ZERO, ST_OK},
    '{CMD_DIV, I64_MAX, ZERO, 1, ZERO, ST_DIVZ},
    '{CMD_REM, I64_MIN, ZERO, 1, ZERO, ST_DIVZ},
    '{CMD_DIV, -64'd7, 64'd2, 0, ZERO, ST_OK},
    '{CMD_REM, -64'd7, 64'd2, 0, ZERO, ST_OK},
    '{CMD_REM, 64'd7, -64'd2, 0, ZERO, ST_OK},
    '{CMD_DIV, I64_MIN, I64_MAX, 0, ZERO, ST_OK},
    '{CMD_NEG, I64_MIN, MINUS_ONE, 1, ZERO, ST_OVF},
    '{CMD_NEG, I64_MAX, ZERO, 1, I64_MIN + 64'd1, ST_OK},
    '{CMD_SPARE_LO, I64_MAX, I64_MAX, 1, ZERO, ST_OK},
    '{CMD_SPARE_HI, MINUS_ONE, MINUS_ONE, 1, ZERO, ST_OK}
  };

  // Stimulus: reset, directed table, then random operations.
  initial begin
    logic [CMD_W-1:0] cmd;
    alu_result_t      typed;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_ADD;
    in_operand_a <= ZERO;
    in_operand_b <= ZERO;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      typed = checked_op(directed[i].cmd, directed[i].a, directed[i].b);
      // Hand-typed rows also check the predictor itself.
      if (directed[i].known &&
          (typed.result !== directed[i].result || typed.status !== directed[i].status)) begin
        $error("directed row %0d: table %h/%0d, predictor %h/%0d", i, directed[i].result,
               directed[i].status, typed.result, typed.status);
        mismatches++;
      end
      maybe_idle();
      send_op(directed[i].cmd, directed[i].a, directed[i].b);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      no_idle = (n >= 300 && n < 450);
      // Hold off until the block has drained completely.
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3: cmd = CMD_ADD;
        4, 5, 6, 7: cmd = CMD_SUB;
        8, 9, 10, 11: cmd = CMD_MUL;
        12, 13: cmd = CMD_DIV;
        14, 15: cmd = CMD_REM;
        16, 17: cmd = CMD_NEG;
        18: cmd = CMD_SPARE_LO;
        default: cmd = CMD_SPARE_HI;
      endcase
      maybe_idle();
      send_op(cmd, pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
    no_idle = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
